[rtl/core/sorted_software_timer_queue_assert.svh]
// Assertion macros used by the timer queue RTL.
`ifndef SORTED_SOFTWARE_TIMER_QUEUE_ASSERT_SVH
`define SORTED_SOFTWARE_TIMER_QUEUE_ASSERT_SVH

// Concurrent check on the rising clock, off while reset is low.
`define STQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same, but also checked while reset is low.
`define STQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/stq_pkg.sv]
package stq_pkg;

	localparam int SLOT_W  = 5;
	localparam int TIME_W  = 32;
	localparam int DEST_W  = 8;
	localparam int VALUE_W = 32;
	localparam int ACT_W   = 3;

	localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FREE  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SET   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ARM   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TICK  = 3'd4;

	localparam logic [1:0] ST_UNUSED  = 2'd0;
	localparam logic [1:0] ST_ALLOC   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;

	localparam logic REPLY_ALLOC  = 1'b0;
	localparam logic REPLY_EXPIRY = 1'b1;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [SLOT_W-1:0]  slot;
		logic [TIME_W-1:0]  delay;
		logic [DEST_W-1:0]  dest_queue;
		logic [VALUE_W-1:0] event_value;
	} req_t;

	typedef struct packed {
		logic               reply_kind;
		logic [SLOT_W-1:0]  slot_out;
		logic               alloc_ok;
		logic [DEST_W-1:0]  dest_out;
		logic [VALUE_W-1:0] value_out;
		logic               last;
	} rsp_t;

endpackage

[rtl/core/stq_if.sv]
interface stq_req_if import stq_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface stq_rsp_if import stq_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/stq_out_reg.sv]
module stq_out_reg import stq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  rsp_t   push_data,
	output logic   full,
	stq_rsp_if.source rsp
);
	// One-entry output register: the item holds until taken; push only while not full.
	logic valid_q;
	rsp_t data_q;

	assign full = valid_q;
	assign rsp.valid = valid_q;
	assign rsp.data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end
endmodule

[rtl/core/sorted_software_timer_queue.sv]
// Pool of NUM_TIMERS one-shot timers (up to 32 usable) kept on a linked list in expiry order.
// One item is taken at a time: ready drops from the cycle after an accept until the item is
// done. Free, set and unknown actions finish in the idle state; allocate checks one slot
// status per cycle; arm, when the timer goes to the list head, links it there at once,
// otherwise it walks the list one entry per cycle; tick releases each expired timer in turn,
// one list head read from the slot memories at a time. Allocate and tick also wait while
// the output register still holds an untaken result.
// The per-slot expiry, destination, value and link stores are memories with registered reads.
`include "sorted_software_timer_queue_assert.svh"
module sorted_software_timer_queue import stq_pkg::*; #(
	parameter int NUM_TIMERS = 32
) (
	input logic clk,
	input logic arst_n,
	stq_req_if.sink  req,
	stq_rsp_if.source rsp
);
	localparam int POOL = (NUM_TIMERS < 32) ? NUM_TIMERS : 32;
	localparam int CNT_W = $clog2(POOL + 1);
	localparam int IDX_W = $clog2(POOL);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ALLOC  = 3'd1;
	localparam logic [2:0] S_ARMRD  = 3'd2;
	localparam logic [2:0] S_ARMWK  = 3'd3;
	localparam logic [2:0] S_TKRD   = 3'd4;
	localparam logic [2:0] S_TKCHK  = 3'd5;
	localparam logic [2:0] S_ARMLNK = 3'd6;

	logic [2:0] state_q;
	req_t req_q;
	logic busy_q;
	logic [TIME_W-1:0] tick_q;
	logic [1:0] status_q [POOL];
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0] run_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] prev_q;
	logic [CNT_W-1:0] step_q;
	logic [TIME_W-1:0] exp_new_q;
	rsp_t hold_q;
	logic hold_v_q;

	logic [TIME_W-1:0] expiry_mem [POOL];
	logic [DEST_W-1:0] dest_mem [POOL];
	logic [VALUE_W-1:0] value_mem [POOL];
	logic [SLOT_W-1:0] link_mem [POOL];

	logic [TIME_W-1:0] exp_rd_q;
	logic [DEST_W-1:0] dest_rd_q;
	logic [VALUE_W-1:0] value_rd_q;
	logic [SLOT_W-1:0] link_rd_q;

	logic out_full;
	logic push;
	rsp_t push_data;

	logic [SLOT_W-1:0] rd_addr;
	logic exp_we, link_we, set_we;
	logic [SLOT_W-1:0] link_wa;
	logic [SLOT_W-1:0] link_wd;
	logic in_range;
	logic [IDX_W-1:0] pidx, ridx;
	logic take;
	logic [1:0] cur_status;
	logic expire;
	logic fits;
	logic arm_head;
	logic walk_last;

	assign take = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && !busy_q;
	assign in_range = ({27'd0, req_q.slot} < 32'(POOL));
	assign pidx = req_q.slot[IDX_W-1:0];
	assign ridx = idx_q[IDX_W-1:0];
	assign cur_status = status_q[ridx];
	// Head is due: list not empty and its expiry not past the count.
	assign expire = (run_q != '0) && !(exp_rd_q > tick_q);
	assign fits = (exp_new_q <= exp_rd_q);
	assign arm_head = (run_q == '0) || fits;
	assign walk_last = ((step_q + CNT_W'(1)) >= run_q);

	stq_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.full(out_full), .rsp(rsp)
	);

	// Memory read port: registered, one address per cycle.
	always_ff @(posedge clk) begin
		exp_rd_q   <= expiry_mem[rd_addr[IDX_W-1:0]];
		dest_rd_q  <= dest_mem[rd_addr[IDX_W-1:0]];
		value_rd_q <= value_mem[rd_addr[IDX_W-1:0]];
		link_rd_q  <= link_mem[rd_addr[IDX_W-1:0]];
		if (exp_we) begin
			expiry_mem[pidx] <= exp_new_q;
		end
		if (link_we) begin
			link_mem[link_wa[IDX_W-1:0]] <= link_wd;
		end
		if (set_we) begin
			dest_mem[pidx] <= req_q.dest_queue;
			value_mem[pidx] <= req_q.event_value;
		end
	end

	// Request register: captured on accept, drives the sequencer.
	always_ff @(posedge clk) begin
		if (take) begin
			req_q <= req.data;
		end
	end

	always_comb begin
		rd_addr = head_q;
		exp_we = 1'b0;
		link_we = 1'b0;
		set_we = 1'b0;
		link_wa = req_q.slot;
		link_wd = head_q;
		push = 1'b0;
		push_data = hold_q;
		unique case (state_q)
			S_IDLE: begin
				set_we = busy_q && (req_q.action == ACT_SET) && in_range;
			end
			S_ALLOC: begin
				if ((cur_status == ST_UNUSED || {27'd0, idx_q} == 32'(POOL - 1)) && !out_full) begin
					push = 1'b1;
					push_data = '0;
					push_data.reply_kind = REPLY_ALLOC;
					push_data.alloc_ok = (cur_status == ST_UNUSED);
					push_data.slot_out = (cur_status == ST_UNUSED) ? idx_q : '0;
					push_data.last = 1'b1;
				end
			end
			S_ARMRD: begin
				exp_we = 1'b1;
				rd_addr = link_rd_q;
				if (arm_head) begin
					link_we = 1'b1;
					link_wd = head_q;
				end else if (run_q == CNT_W'(1)) begin
					link_we = 1'b1;
					link_wd = link_rd_q;
				end
			end
			S_ARMWK: begin
				// idx_q is the candidate successor; exp_rd_q and link_rd_q are its entries.
				rd_addr = link_rd_q;
				if (fits) begin
					link_we = 1'b1;
					link_wd = idx_q;
				end else if (walk_last) begin
					link_we = 1'b1;
					link_wd = link_rd_q;
				end
			end
			S_ARMLNK: begin
				link_we = 1'b1;
				link_wa = prev_q;
				link_wd = req_q.slot;
			end
			S_TKCHK: begin
				// Release the held expiry once it is known whether another one follows.
				if (hold_v_q && !out_full) begin
					push = 1'b1;
					push_data.last = !expire;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			tick_q <= '0;
			head_q <= '0;
			run_q <= '0;
			idx_q <= '0;
			prev_q <= '0;
			step_q <= '0;
			exp_new_q <= '0;
			hold_q <= '0;
			hold_v_q <= 1'b0;
			for (int i = 0; i < POOL; i++) begin
				status_q[i] <= ST_UNUSED;
			end
		end else begin
			busy_q <= take;
			unique case (state_q)
				S_IDLE: begin
					if (busy_q) begin
						unique case (req_q.action)
							ACT_ALLOC: begin
								idx_q <= '0;
								state_q <= S_ALLOC;
							end
							ACT_FREE: begin
								if (in_range && status_q[pidx] != ST_RUNNING) begin
									status_q[pidx] <= ST_UNUSED;
								end
							end
							ACT_ARM: begin
								if (in_range && status_q[pidx] != ST_RUNNING) begin
									exp_new_q <= tick_q + req_q.delay;
									state_q <= S_ARMRD;
								end
							end
							ACT_TICK: begin
								tick_q <= tick_q + 32'd1;
								state_q <= S_TKRD;
							end
							default: ;
						endcase
					end
				end
				S_ALLOC: begin
					if (cur_status == ST_UNUSED || {27'd0, idx_q} == 32'(POOL - 1)) begin
						if (!out_full) begin
							if (cur_status == ST_UNUSED) begin
								status_q[ridx] <= ST_ALLOC;
							end
							state_q <= S_IDLE;
						end
					end else begin
						idx_q <= idx_q + 5'd1;
					end
				end
				S_ARMRD: begin
					status_q[pidx] <= ST_RUNNING;
					if (arm_head) begin
						head_q <= req_q.slot;
						run_q <= run_q + CNT_W'(1);
						state_q <= S_IDLE;
					end else begin
						prev_q <= head_q;
						if (run_q == CNT_W'(1)) begin
							state_q <= S_ARMLNK;
						end else begin
							idx_q <= link_rd_q;
							step_q <= CNT_W'(1);
							state_q <= S_ARMWK;
						end
					end
				end
				S_ARMWK: begin
					if (fits) begin
						state_q <= S_ARMLNK;
					end else if (walk_last) begin
						prev_q <= idx_q;
						state_q <= S_ARMLNK;
					end else begin
						prev_q <= idx_q;
						idx_q <= link_rd_q;
						step_q <= step_q + CNT_W'(1);
					end
				end
				S_ARMLNK: begin
					run_q <= run_q + CNT_W'(1);
					state_q <= S_IDLE;
				end
				S_TKRD: state_q <= S_TKCHK;
				S_TKCHK: begin
					if (!(hold_v_q && out_full)) begin
						if (expire) begin
							status_q[head_q[IDX_W-1:0]] <= ST_ALLOC;
							run_q <= run_q - CNT_W'(1);
							head_q <= link_rd_q;
							hold_q.reply_kind <= REPLY_EXPIRY;
							hold_q.slot_out <= head_q;
							hold_q.alloc_ok <= 1'b0;
							hold_q.dest_out <= dest_rd_q;
							hold_q.value_out <= value_rd_q;
							hold_q.last <= 1'b0;
							hold_v_q <= 1'b1;
							state_q <= S_TKRD;
						end else begin
							hold_v_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`STQ_ASSERT(a_ready_idle, req.ready |-> (state_q == S_IDLE && !busy_q), "ready outside idle")
	`STQ_ASSERT(a_run_bound, 32'(run_q) <= 32'(POOL), "running count above pool")
	`STQ_ASSERT(a_push_room, push |-> !out_full, "push into full output")
	`STQ_ASSERT(a_hold_tick, hold_v_q |-> (state_q == S_TKRD || state_q == S_TKCHK), "held expiry outside tick")
endmodule
